// File: rtl/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared constants, operation codes and bundle types of the text console.
// ----------------------------------------------------------------------------
package tmcw_pkg;

	// Screen geometry limits and store size
	localparam int MAX_COLS   = 80;
	localparam int MAX_ROWS   = 25;
	localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);

	// Field widths
	localparam int FUNC_W    = 2;
	localparam int CHAR_W    = 8;
	localparam int ATTR_W    = 8;
	localparam int CELL_W    = ATTR_W + CHAR_W;
	localparam int CADDR_W   = 11;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int CIDX_W    = 11;
	localparam int LIN_W     = ROW_W + COL_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	// Stream widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 1;

	// Item queue
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;
	localparam int                TAB_STEP = 8;

	// Register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_ATTR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
	localparam logic [COL_W-1:0]  COLS_RESET = 7'd80;
	localparam logic [ROW_W-1:0]  ROWS_RESET = 5'd25;
	localparam logic [CELL_W-1:0] INIT_CELL  = 16'h0F20;

	typedef enum logic [3:0] {
		OP_STORE = 4'd0,
		OP_BS    = 4'd1,
		OP_TAB   = 4'd2,
		OP_CR    = 4'd3,
		OP_LF    = 4'd4,
		OP_IGN   = 4'd5,
		OP_CLEAR = 4'd6,
		OP_READ  = 4'd7,
		OP_NONE  = 4'd8
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CHAR_W-1:0]  chr;
		logic [CADDR_W-1:0] addr;
	} q_item_t;

	typedef struct packed {
		logic [ATTR_W-1:0] attr;
		logic [COL_W-1:0]  nc;
		logic [ROW_W-1:0]  nr;
	} cfg_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_val;
		logic              scrolled;
		logic [CIDX_W-1:0] index;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} res_t;

endpackage

// File: rtl/tmcw_ram.sv
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/tmcw_front.sv
// ----------------------------------------------------------------------------
// tmcw_front
// Input side: accept requests, classify them into operations, push to queue.
// ----------------------------------------------------------------------------
module tmcw_front (
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tmcw_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // char_code, cell_address
	input  logic [tmcw_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // func
	input  logic                             init_busy,
	input  logic                             q_full,
	output logic                             push,
	output tmcw_pkg::q_item_t                item
);
	import tmcw_pkg::*;

	function automatic op_t classify(input logic [FUNC_W-1:0] func,
	                                 input logic [CHAR_W-1:0] chr);
		op_t op;
		op = OP_NONE;
		unique case (func)
			FUNC_PUT: begin
				if (chr == CH_BS) op = OP_BS;
				else if (chr == CH_TAB) op = OP_TAB;
				else if (chr == CH_CR) op = OP_CR;
				else if (chr == CH_LF) op = OP_LF;
				else if (chr >= CH_SPACE && chr <= CH_LAST) op = OP_STORE;
				else op = OP_IGN;
			end
			FUNC_CLEAR: op = OP_CLEAR;
			FUNC_READ:  op = OP_READ;
			default:    op = OP_NONE;
		endcase
		return op;
	endfunction

	// Hold off while the store is being initialized or the queue is full
	assign s_axis_tready = !init_busy && !q_full;
	assign push          = s_axis_tvalid && s_axis_tready;

	assign item.op   = classify(s_axis_tuser[FUNC_W-1:0], s_axis_tdata[CHAR_W-1:0]);
	assign item.chr  = s_axis_tdata[CHAR_W-1:0];
	assign item.addr = s_axis_tdata[CHAR_W +: CADDR_W];

endmodule

// File: rtl/tmcw_queue.sv
// ----------------------------------------------------------------------------
// tmcw_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module tmcw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tmcw_pkg::q_item_t push_item,
	input  logic              pop,
	output tmcw_pkg::q_item_t head,
	output logic              empty,
	output logic              full
);
	import tmcw_pkg::*;

	q_item_t              entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	function automatic logic [Q_PTR_W-1:0] next_ptr(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: rtl/tmcw_back.sv
// ----------------------------------------------------------------------------
// tmcw_back
// Execution side: cursor, screen store sequencing, scroll and result register.
// ----------------------------------------------------------------------------
module tmcw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tmcw_pkg::cfg_t    cfg,
	input  tmcw_pkg::q_item_t head,
	input  logic              q_empty,
	output logic              pop,
	output logic              init_busy,
	output logic              m_valid,
	input  logic              m_ready,
	output tmcw_pkg::res_t    res
);
	import tmcw_pkg::*;

	typedef enum logic [9:0] {
		S_INIT   = 10'b00_0000_0001,
		S_IDLE   = 10'b00_0000_0010,
		S_EXEC   = 10'b00_0000_0100,
		S_WRAP   = 10'b00_0000_1000,
		S_SCR1   = 10'b00_0001_0000,
		S_SCR2   = 10'b00_0010_0000,
		S_COPY   = 10'b00_0100_0000,
		S_FILL   = 10'b00_1000_0000,
		S_RDWAIT = 10'b01_0000_0000,
		S_RESULT = 10'b10_0000_0000
	} state_t;

	state_t              state_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	op_t                 op_q;
	logic [CHAR_W-1:0]   chr_q;
	logic [CADDR_W-1:0]  addr_q;
	logic                wr_pend_q;
	logic [LIN_W-1:0]    wr_idx_q;
	logic [CELL_W-1:0]   wr_data_q;
	logic [ROW_W-1:0]    shift_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    off_q;
	logic [CNT_W-1:0]    keep_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                pend_s1;
	logic [ADDR_W-1:0]   dst_s1;
	logic                scr_q;
	logic [CELL_W-1:0]   cell_q;
	logic                m_valid_q;
	res_t                res_q;

	logic                ram_wr_en;
	logic [ADDR_W-1:0]   ram_wr_addr;
	logic [CELL_W-1:0]   ram_wr_data;
	logic                ram_rd_en;
	logic [ADDR_W-1:0]   ram_rd_addr;
	logic [CELL_W-1:0]   ram_rd_data;

	logic [CELL_W-1:0]   blank;
	logic [COL_W-1:0]    exec_col;
	logic [ROW_W-1:0]    exec_row;
	logic [COL_W-1:0]    exec_wcol;
	logic                exec_wr;
	logic [CELL_W-1:0]   exec_data;
	logic [LIN_W-1:0]    exec_idx;
	logic [COL_W:0]      tab_sum;
	logic [COL_W-1:0]    wrap_col;
	logic [ROW_W-1:0]    wrap_row;
	logic                need_scroll;
	logic [ROW_W-1:0]    shift_raw;
	logic [ROW_W-1:0]    shift_cap;
	logic [CNT_W-1:0]    area;
	logic                rd_in_range;
	logic                copy_rd;
	logic [CNT_W:0]      copy_src;
	logic                out_load;
	logic [LIN_W-1:0]    cur_lin;

	assign blank       = {cfg.attr, CH_SPACE};
	assign area        = CNT_W'(cfg.nr) * CNT_W'(cfg.nc);
	assign rd_in_range = (addr_q < CADDR_W'(CELL_COUNT));
	assign copy_rd     = (cnt_q < keep_q);
	assign copy_src    = {1'b0, cnt_q} + {1'b0, off_q};
	assign out_load    = !m_valid_q || m_ready;
	assign cur_lin     = LIN_W'(row_q) * LIN_W'(cfg.nc) + LIN_W'(col_q);

	assign pop       = (state_q == S_IDLE) && !q_empty;
	assign init_busy = (state_q == S_INIT);
	assign m_valid   = m_valid_q;
	assign res       = res_q;

	// Character interpretation, before the column wrap
	always_comb begin
		exec_col  = col_q;
		exec_row  = row_q;
		exec_wcol = col_q;
		exec_wr   = 1'b0;
		exec_data = {cfg.attr, chr_q};
		tab_sum   = {1'b0, col_q} + (COL_W + 1)'(TAB_STEP);
		unique case (op_q)
			OP_STORE: begin
				exec_wr  = 1'b1;
				exec_col = col_q + 1'b1;
			end
			OP_BS: begin
				if (col_q != '0) exec_col = col_q - 1'b1;
				exec_wcol = exec_col;
				exec_wr   = 1'b1;
				exec_data = blank;
			end
			OP_TAB: exec_col = tab_sum[COL_W-1:0] & ~COL_W'(TAB_STEP - 1);
			OP_CR:  exec_col = '0;
			OP_LF: begin
				exec_col = '0;
				exec_row = row_q + 1'b1;
			end
			default: ;
		endcase
		exec_idx = LIN_W'(row_q) * LIN_W'(cfg.nc) + LIN_W'(exec_wcol);
	end

	// Column wrap and scroll depth
	always_comb begin
		wrap_col = col_q;
		wrap_row = row_q;
		if (col_q >= cfg.nc) begin
			wrap_col = '0;
			wrap_row = row_q + 1'b1;
		end
		need_scroll = (wrap_row >= cfg.nr);
		shift_raw   = wrap_row - cfg.nr + 1'b1;
		shift_cap   = (shift_raw > cfg.nr) ? cfg.nr : shift_raw;
	end

	// Store port selection
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = cnt_q[ADDR_W-1:0];
		ram_wr_data = blank;
		ram_rd_en   = 1'b0;
		ram_rd_addr = copy_src[ADDR_W-1:0];
		unique case (state_q)
			S_INIT: begin
				ram_wr_en   = 1'b1;
				ram_wr_data = INIT_CELL;
			end
			S_EXEC: begin
				ram_rd_en   = (op_q == OP_READ) && rd_in_range;
				ram_rd_addr = addr_q[ADDR_W-1:0];
			end
			S_WRAP: begin
				ram_wr_en   = wr_pend_q && (wr_idx_q < LIN_W'(CELL_COUNT));
				ram_wr_addr = wr_idx_q[ADDR_W-1:0];
				ram_wr_data = wr_data_q;
			end
			S_COPY: begin
				ram_rd_en   = copy_rd;
				ram_wr_en   = pend_s1;
				ram_wr_addr = dst_s1;
				ram_wr_data = ram_rd_data;
			end
			S_FILL: ram_wr_en = (cnt_q < total_q);
			default: ;
		endcase
	end

	tmcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			col_q   <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (!q_empty) state_q <= S_EXEC;
				end
				S_EXEC: begin
					unique case (op_q)
						OP_CLEAR: begin
							col_q   <= '0;
							row_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_FILL;
						end
						OP_READ: state_q <= S_RDWAIT;
						OP_NONE: state_q <= S_RESULT;
						default: begin
							col_q   <= exec_col;
							row_q   <= exec_row;
							state_q <= S_WRAP;
						end
					endcase
				end
				S_WRAP: begin
					col_q <= wrap_col;
					if (need_scroll) begin
						row_q   <= cfg.nr - 1'b1;
						state_q <= S_SCR1;
					end else begin
						row_q   <= wrap_row;
						state_q <= S_RESULT;
					end
				end
				S_SCR1: state_q <= S_SCR2;
				S_SCR2: begin
					cnt_q   <= '0;
					state_q <= S_COPY;
				end
				S_COPY: begin
					// Read one cell ahead, write it in the next cycle
					pend_s1 <= copy_rd;
					if (copy_rd) cnt_q <= cnt_q + 1'b1;
					else if (!pend_s1) state_q <= S_FILL;
				end
				S_FILL: begin
					if (cnt_q < total_q) cnt_q <= cnt_q + 1'b1;
					else state_q <= S_RESULT;
				end
				S_RDWAIT: state_q <= S_RESULT;
				S_RESULT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Per-request payload
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= head.op;
			chr_q  <= head.chr;
			addr_q <= head.addr;
			scr_q  <= 1'b0;
			cell_q <= '0;
		end
		if (state_q == S_EXEC) begin
			wr_pend_q <= exec_wr;
			wr_idx_q  <= exec_idx;
			wr_data_q <= exec_data;
			total_q   <= area;
		end
		if (state_q == S_WRAP && need_scroll) begin
			shift_q <= shift_cap;
			total_q <= area;
			scr_q   <= 1'b1;
		end
		if (state_q == S_SCR1) off_q <= CNT_W'(shift_q) * CNT_W'(cfg.nc);
		if (state_q == S_SCR2) keep_q <= total_q - off_q;
		if (state_q == S_COPY) dst_s1 <= cnt_q[ADDR_W-1:0];
		if (state_q == S_RDWAIT) cell_q <= rd_in_range ? ram_rd_data : '0;
		if (state_q == S_RESULT && out_load) begin
			res_q.col      <= col_q;
			res_q.row      <= row_q;
			res_q.index    <= cur_lin[CIDX_W-1:0];
			res_q.scrolled <= scr_q;
			res_q.cell_val <= cell_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_wr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> (ram_wr_addr < ADDR_W'(CELL_COUNT)))
		else $error("store write beyond the screen");

	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY && ram_wr_en && ram_rd_en) |-> (ram_wr_addr < ram_rd_addr))
		else $error("scroll copy overtook its own reads");

	a_copy_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_s1)
		else $error("copy write still pending in idle");

	a_no_pop_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> !pop)
		else $error("request taken during store initialization");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && m_valid_q && !m_ready) |=> (state_q == S_RESULT))
		else $error("result dropped while output slot busy");
`endif

endmodule

// File: rtl/text_mode_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit
// Character-cell text console with screen store, cursor and scrolling.
// ----------------------------------------------------------------------------
// A put or read request goes from the request queue to its result through pop,
// execute, wrap or read wait, and result load; a request with the spare
// function code skips the wrap. A clear blanks rows*columns cells, and a put
// that scrolls moves or blanks rows*columns cells (blanks only, when the whole
// screen scrolls away): the screen store has one write port, so every moved or
// blanked cell takes a write of its own. After reset the store is initialized
// one cell per cycle, all 2000 cells, during which s_axis_tready stays low
// (configuration writes are taken as usual). A two-entry request queue and the
// output register let new requests be accepted while a result waits to be taken.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Request stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tmcw_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // char_code, cell_address
	input  logic [tmcw_pkg::S_TUSER_W-1:0]     s_axis_tuser,  // func
	// Result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// cursor_col, cursor_row, cursor_index, cell_value
	output logic [tmcw_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	output logic [tmcw_pkg::M_TUSER_W-1:0]     m_axis_tuser,  // scrolled
	// Configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tmcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tmcw_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import tmcw_pkg::*;

	logic [ATTR_W-1:0] attr_q;
	logic [COL_W-1:0]  cols_q;
	logic [ROW_W-1:0]  rows_q;

	cfg_t    cfg;
	q_item_t push_item;
	q_item_t head;
	res_t    res;
	logic    push;
	logic    pop;
	logic    q_empty;
	logic    q_full;
	logic    init_busy;

	// Registers accept a write in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ATTR: attr_q <= cfg_data[ATTR_W-1:0];
				CFG_COLS: cols_q <= cfg_data[COL_W-1:0];
				CFG_ROWS: rows_q <= cfg_data[ROW_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// Clamp geometry into 1..MAX_COLS and 1..MAX_ROWS
	always_comb begin
		cfg.attr = attr_q;
		if (cols_q == '0) cfg.nc = COL_W'(1);
		else if (cols_q > COL_W'(MAX_COLS)) cfg.nc = COL_W'(MAX_COLS);
		else cfg.nc = cols_q;
		if (rows_q == '0) cfg.nr = ROW_W'(1);
		else if (rows_q > ROW_W'(MAX_ROWS)) cfg.nr = ROW_W'(MAX_ROWS);
		else cfg.nr = rows_q;
	end

	// Front: accept and classify requests
	tmcw_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.init_busy     (init_busy),
		.q_full        (q_full),
		.push          (push),
		.item          (push_item)
	);

	// Queue between the two sides
	tmcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back: cursor, store and result
	tmcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.init_busy (init_busy),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.res       (res)
	);

	// Pack the result, pad to whole bytes
	assign m_axis_tdata = {1'b0, res.cell_val, res.index, res.row, res.col};
	assign m_axis_tuser = res.scrolled;

endmodule

// File: bench/text_mode_console_writer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit_tb
// Self-checking bench for the text console: a cycle-free shadow of the
// screen store and cursor predicts every report, and a checker compares each
// report taken from the result stream against the oldest prediction.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit_tb;
	import tmcw_pkg::*;

	// Function code with no meaning to the console: reports the cursor only
	localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LATENCY_TAIL   = 64;
	localparam int HOLD_CYCLES    = 600;

	// One expected report, unpacked into its fields
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [CIDX_W-1:0] index;
		logic              scrolled;
		logic [CELL_W-1:0] cell_val;
	} cursor_report_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [M_TUSER_W-1:0] m_axis_tuser;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_DAT_W-1:0] cfg_data      = '0;

	text_mode_console_writer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Shadow console: screen store, cursor and registers as the block keeps them
	// ------------------------------------------------------------------------
	logic [CELL_W-1:0] shadow_cells [0:CELL_COUNT-1];
	int                cur_col;
	int                cur_row;
	logic [ATTR_W-1:0] attr_reg;
	logic [COL_W-1:0]  cols_reg;
	logic [ROW_W-1:0]  rows_reg;

	cursor_report_t pending_reports [$];
	int             mismatches = 0;

	// Clamp the register values to the geometry the store can hold
	function automatic int eff_cols();
		if (cols_reg == 0) return 1;
		if (cols_reg > MAX_COLS) return MAX_COLS;
		return int'(cols_reg);
	endfunction

	function automatic int eff_rows();
		if (rows_reg == 0) return 1;
		if (rows_reg > MAX_ROWS) return MAX_ROWS;
		return int'(rows_reg);
	endfunction

	// Drop writes that land beyond the store
	function automatic void store_cell(int idx, logic [CELL_W-1:0] v);
		if (idx < CELL_COUNT) shadow_cells[idx] = v;
	endfunction

	// Apply one request to the shadow console and return the report it causes
	function automatic cursor_report_t console_step(logic [FUNC_W-1:0] fn,
			logic [CHAR_W-1:0] code, logic [CADDR_W-1:0] addr);
		cursor_report_t    r;
		int                nc;
		int                nr;
		int                shift;
		int                i;
		logic [CELL_W-1:0] blank;
		nc    = eff_cols();
		nr    = eff_rows();
		blank = {attr_reg, CH_SPACE};
		r     = '0;
		if (fn == FUNC_PUT) begin
			if (code == CH_BS) begin
				if (cur_col != 0) cur_col--;
				store_cell(cur_row * nc + cur_col, blank);
			end else if (code == CH_TAB) begin
				cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
			end else if (code == CH_CR) begin
				cur_col = 0;
			end else if (code == CH_LF) begin
				cur_col = 0;
				cur_row++;
			end else if (code >= CH_SPACE && code <= CH_LAST) begin
				store_cell(cur_row * nc + cur_col, {attr_reg, code});
				cur_col++;
			end
			// Wrap at the right margin
			if (cur_col >= nc) begin
				cur_col = 0;
				cur_row++;
			end
			// Scroll by as many rows as the cursor fell below the screen
			if (cur_row >= nr) begin
				shift = cur_row - nr + 1;
				if (shift > nr) shift = nr;
				for (i = 0; i < (nr - shift) * nc; i++)
					shadow_cells[i] = shadow_cells[i + shift * nc];
				for (i = (nr - shift) * nc; i < nr * nc; i++)
					store_cell(i, blank);
				cur_row    = nr - 1;
				r.scrolled = 1'b1;
			end
		end else if (fn == FUNC_CLEAR) begin
			for (i = 0; i < nr * nc; i++) store_cell(i, blank);
			cur_col = 0;
			cur_row = 0;
		end else if (fn == FUNC_READ) begin
			if (addr < CELL_COUNT) r.cell_val = shadow_cells[addr];
		end
		r.col   = cur_col[COL_W-1:0];
		r.row   = cur_row[ROW_W-1:0];
		r.index = CIDX_W'(cur_row * nc + cur_col);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Request side: bursts of random length separated by random gaps
	// ------------------------------------------------------------------------
	int burst_left = 0;
	bit gapless    = 1'b0;

	// Offer one request, hold it until taken, then log its predicted report
	task automatic send_request(logic [FUNC_W-1:0] fn, logic [CHAR_W-1:0] code,
			logic [CADDR_W-1:0] addr);
		int gap;
		if (!gapless && burst_left == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			// Mostly short bursts, sometimes a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
			                                          : $urandom_range(1, 8);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_TDATA_W - CADDR_W - CHAR_W){1'b0}}, addr, code};
		s_axis_tuser  <= fn;
		do @(posedge clk); while (!s_axis_tready);
		pending_reports.push_back(console_step(fn, code, addr));
		if (burst_left > 0) burst_left--;
	endtask

	// Draw a request weighted toward text flow; keep clears rare, they walk the screen
	task automatic send_random_request();
		int                 pick;
		int                 used;
		logic [FUNC_W-1:0]  fn;
		logic [CHAR_W-1:0]  code;
		logic [CADDR_W-1:0] addr;
		used = eff_cols() * eff_rows();
		pick = $urandom_range(0, 99);
		if (pick < 80)      fn = FUNC_PUT;
		else if (pick < 95) fn = FUNC_READ;
		else if (pick < 97) fn = FUNC_CLEAR;
		else                fn = FUNC_NOP;
		pick = $urandom_range(0, 99);
		if (pick < 62)      code = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
		else if (pick < 70) code = CH_LF;
		else if (pick < 74) code = CH_CR;
		else if (pick < 80) code = CH_TAB;
		else if (pick < 88) code = CH_BS;
		else                code = CHAR_W'($urandom_range(0, 255));
		// Read mostly inside the screen in use, sometimes anywhere the field reaches
		if ($urandom_range(0, 9) < 7) addr = CADDR_W'($urandom_range(0, used - 1));
		else                          addr = CADDR_W'($urandom_range(0, (1 << CADDR_W) - 1));
		send_request(fn, code, addr);
	endtask

	// Release the request stream and wait until every report has come back
	task automatic drain_reports();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	// Write one register while the console is idle
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		drain_reports();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ATTR: attr_reg = val;
			CFG_COLS: cols_reg = val[COL_W-1:0];
			CFG_ROWS: rows_reg = val[ROW_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_geometry(logic [CFG_DAT_W-1:0] attr, logic [CFG_DAT_W-1:0] cols,
			logic [CFG_DAT_W-1:0] rows);
		write_register(CFG_ATTR, attr);
		write_register(CFG_COLS, cols);
		write_register(CFG_ROWS, rows);
	endtask

	// ------------------------------------------------------------------------
	// Result side: stall pattern of its own, plus an on-demand long hold-off
	// ------------------------------------------------------------------------
	bit hold_request = 1'b0;

	initial begin
		int hold_left;
		int stretch_left;
		int stall_mode;
		int beat;
		hold_left    = 0;
		stretch_left = 0;
		stall_mode   = 0;
		beat         = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stall_mode   = $urandom_range(0, 3);
					stretch_left = $urandom_range(20, 200);
				end
				stretch_left--;
				beat++;
				case (stall_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ((beat % 7) >= 3);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Report checker: compare each taken report with the oldest prediction
	// ------------------------------------------------------------------------
	cursor_report_t want;

	function automatic void check_field(string what, int expected, int actual);
		if (expected != actual) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
			         $time, what, expected, actual);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: report with no request pending: tdata 0x%0h tuser 0x%0h",
				         $time, m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				// tdata from bit 0: col, row, index, cell value; tuser: scrolled
				check_field("cursor_col", int'(want.col), int'(m_axis_tdata[6:0]));
				check_field("cursor_row", int'(want.row), int'(m_axis_tdata[11:7]));
				check_field("cursor_index", int'(want.index), int'(m_axis_tdata[22:12]));
				check_field("cell_value", int'(want.cell_val), int'(m_axis_tdata[38:23]));
				check_field("scrolled", int'(want.scrolled), int'(m_axis_tuser[0]));
			end
		end
	end

	// Watchdog: end the run when no channel moves anything for too long
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog: no handshake for %0d cycles", $time, idle_cycles);
			$display("** text_mode_console_writer_unit: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Walk every character class on the reset screen, plus reads and the spare code
	task automatic test_character_codes();
		send_request(FUNC_READ, 8'h00, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd1999);
		send_request(FUNC_READ, 8'h00, 11'd2000);   // just past the store
		send_request(FUNC_READ, 8'h00, 11'h7FF);
		send_request(FUNC_PUT, 8'h48, 11'd0);
		send_request(FUNC_PUT, CH_SPACE, 11'd0);
		send_request(FUNC_PUT, CH_LAST, 11'd0);
		send_request(FUNC_PUT, 8'h1F, 11'd0);       // control code, ignored
		send_request(FUNC_PUT, 8'h00, 11'd0);
		send_request(FUNC_PUT, 8'h80, 11'd0);       // high half, ignored
		send_request(FUNC_PUT, 8'hFF, 11'd0);
		send_request(FUNC_PUT, 8'h7E, 11'd0);
		send_request(FUNC_PUT, CH_BS, 11'd0);
		send_request(FUNC_PUT, CH_TAB, 11'd0);
		send_request(FUNC_PUT, CH_TAB, 11'd0);
		send_request(FUNC_PUT, CH_CR, 11'd0);
		send_request(FUNC_PUT, CH_BS, 11'd0);       // backspace at the left margin
		send_request(FUNC_PUT, CH_LF, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd3);
		send_request(FUNC_NOP, 8'hFF, 11'h7FF);
		send_request(FUNC_CLEAR, 8'h00, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd2);
		drain_reports();
	endtask

	// Out-of-range registers clamp to one and to the store's geometry
	task automatic test_register_limits();
		set_geometry(8'hFF, 8'd0, 8'd0);
		send_request(FUNC_PUT, 8'h41, 11'd0);       // wraps and scrolls a 1x1 screen
		send_request(FUNC_READ, 8'h00, 11'd0);
		send_request(FUNC_PUT, CH_LF, 11'd0);
		send_request(FUNC_PUT, CH_BS, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd1);
		set_geometry(8'h00, 8'hFF, 8'hFF);
		send_request(FUNC_CLEAR, 8'h00, 11'd0);
		send_request(FUNC_PUT, 8'h5A, 11'd0);
		send_request(FUNC_PUT, CH_TAB, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd1999);
		drain_reports();
	endtask

	// Shrink the screen under the cursor and let a put pull it back in
	task automatic test_shrunken_cursor();
		set_geometry(8'h1E, 8'd80, 8'd25);
		send_request(FUNC_CLEAR, 8'h00, 11'd0);
		repeat (22) send_request(FUNC_PUT, CH_LF, 11'd0);
		send_request(FUNC_PUT, 8'h78, 11'd0);
		send_request(FUNC_PUT, 8'h78, 11'd0);
		write_register(CFG_ROWS, 8'd5);
		send_request(FUNC_NOP, 8'h00, 11'd0);
		send_request(FUNC_PUT, 8'h79, 11'd0);       // scroll by the full screen height
		send_request(FUNC_READ, 8'h00, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd320);
		send_request(FUNC_PUT, CH_LF, 11'd0);       // scroll by one row
		repeat (5) send_request(FUNC_PUT, CH_TAB, 11'd0);
		write_register(CFG_COLS, 8'd10);
		send_request(FUNC_READ, 8'h00, 11'd40);
		send_request(FUNC_PUT, 8'h7A, 11'd0);       // column beyond the narrowed margin
		send_request(FUNC_READ, 8'h00, 11'd80);
		drain_reports();
	endtask

	// Random text through a sweep of geometries, extremes and small screens first
	task automatic test_random_screens();
		byte unsigned phase_cols [8] = '{8'd4, 8'd1, 8'd16, 8'd0, 8'd12, 8'hFF, 8'd80, 8'd40};
		byte unsigned phase_rows [8] = '{8'd3, 8'd1, 8'd2, 8'd0, 8'd6, 8'hFF, 8'd25, 8'd2};
		int           phase_len  [8] = '{200, 120, 200, 80, 200, 150, 100, 150};
		int           p;
		for (p = 0; p < 8; p++) begin
			set_geometry(CFG_DAT_W'($urandom_range(0, 255)), phase_cols[p], phase_rows[p]);
			repeat (phase_len[p]) send_random_request();
		end
		repeat (4) begin
			set_geometry(CFG_DAT_W'($urandom_range(0, 255)), CFG_DAT_W'($urandom_range(1, 24)),
			             CFG_DAT_W'($urandom_range(1, 8)));
			repeat (150) send_random_request();
		end
		drain_reports();
	endtask

	// Hold off the result side while requests keep coming, so the input stalls
	task automatic test_result_backpressure();
		set_geometry(CFG_DAT_W'($urandom_range(0, 255)), 8'd20, 8'd4);
		hold_request = 1'b1;
		gapless      = 1'b1;
		repeat (40) send_random_request();
		gapless = 1'b0;
		drain_reports();
	endtask

	// Pause the request side until every report has arrived, then resume
	task automatic test_sender_pause();
		repeat (5) begin
			repeat (8) send_random_request();
			drain_reports();
		end
	endtask

	initial begin
		int i;
		// Shadow console after reset
		for (i = 0; i < CELL_COUNT; i++) shadow_cells[i] = INIT_CELL;
		cur_col  = 0;
		cur_row  = 0;
		attr_reg = ATTR_RESET;
		cols_reg = COLS_RESET;
		rows_reg = ROWS_RESET;

		// Hold reset, then release it at a falling edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_character_codes();
		test_register_limits();
		test_shrunken_cursor();
		test_result_backpressure();
		test_sender_pause();
		test_random_screens();

		// Let any stray report show up before the verdict
		drain_reports();
		repeat (LATENCY_TAIL) @(posedge clk);
		if (mismatches == 0)
			$display("** text_mode_console_writer_unit: PASSED **");
		else
			$display("** text_mode_console_writer_unit: FAILED **");
		$finish;
	end

endmodule
